// ----- src/srtf_preemptive_scheduler_unit_assert.svh -----
// Assertion shorthands for the scheduler checker.
// Both expect clk and rst_n in the enclosing scope.
`ifndef SRTF_PREEMPTIVE_SCHEDULER_UNIT_ASSERT_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SRTF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srtf scheduler check failed");

// Next-cycle implication.
`define SRTF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srtf scheduler check failed");

`endif

// ----- src/srtf_pkg.sv -----
package srtf_pkg;

    localparam int MAX_PROCS = 16;

    localparam int ARR_W     = 16;
    localparam int BURST_W   = 16;
    localparam int TIME_W    = 21;
    localparam int OUT_IDX_W = 4;

    localparam int JOB_IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int JOB_CNT_W = $clog2(MAX_PROCS + 1);

    // latest tick: last arrival plus every burst
    localparam int TICK_SPAN_W = BURST_W + $clog2(MAX_PROCS + 1);
    localparam int TICK_W      = (TICK_SPAN_W > TIME_W) ? TICK_SPAN_W : TIME_W;

    // queue depth must be a power of two (pointers wrap)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic               keep;   // job fits in the table
        logic               last;   // starts the run
    } job_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_STEP,
        ST_EMIT
    } back_state_t;

endpackage

// ----- src/srtf_if.sv -----
interface srtf_in_if;
    import srtf_pkg::*;

    logic               valid;
    logic               ready;
    logic [ARR_W-1:0]   arrive_tick;
    logic [BURST_W-1:0] burst_len;
    logic               last_job;

    modport source (output valid, output arrive_tick, output burst_len,
                    output last_job, input ready);
    modport sink   (input valid, input arrive_tick, input burst_len,
                    input last_job, output ready);
endinterface

interface srtf_out_if;
    import srtf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] job_index;
    logic [TIME_W-1:0]    finish_tick;
    logic [TIME_W-1:0]    turn_ticks;
    logic [TIME_W-1:0]    wait_time;
    logic                 last_result;

    modport source (output valid, output job_index, output finish_tick,
                    output turn_ticks, output wait_time, output last_result,
                    input ready);
    modport sink   (input valid, input job_index, input finish_tick,
                    input turn_ticks, input wait_time, input last_result,
                    output ready);
endinterface

// ----- src/srtf_front.sv -----
module srtf_front (
    input  logic                clk,
    input  logic                rst_n,
    srtf_in_if.sink             jobs,
    input  srtf_pkg::q_flags_t  q_flags,
    output logic                push,
    output srtf_pkg::job_item_t push_item
);
    import srtf_pkg::*;

    logic [JOB_CNT_W-1:0] held_reg, held_next;
    logic                 xfer;
    logic                 room;

    assign jobs.ready = !q_flags.full;
    assign xfer       = jobs.valid && jobs.ready;
    assign room       = held_reg < JOB_CNT_W'(MAX_PROCS);

    // overflow jobs are dropped, but a dropped last still starts the run
    assign push = xfer && (room || jobs.last_job);

    always_comb
    begin
        push_item.arrival = jobs.arrive_tick;
        push_item.burst   = jobs.burst_len;
        push_item.keep    = room;
        push_item.last    = jobs.last_job;
    end

    always_comb
    begin
        held_next = held_reg;
        if (xfer)
        begin
            if (jobs.last_job)
                held_next = '0;
            else if (room)
                held_next = held_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else
            held_reg <= held_next;
    end

endmodule

// ----- src/srtf_fifo.sv -----
module srtf_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  srtf_pkg::job_item_t push_item,
    input  logic                pop,
    output srtf_pkg::job_item_t head,
    output srtf_pkg::q_flags_t  q_flags
);
    import srtf_pkg::*;

    job_item_t         slot_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign q_flags.full  = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_flags.empty = cnt_reg == '0;
    assign do_push       = push && !q_flags.full;
    assign do_pop        = pop && !q_flags.empty;
    assign head          = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- src/srtf_back.sv -----
module srtf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  srtf_pkg::job_item_t head,
    input  srtf_pkg::q_flags_t  q_flags,
    output logic                pop,
    srtf_out_if.source          results
);
    import srtf_pkg::*;

    // job table
    logic [ARR_W-1:0]   arr_mem   [MAX_PROCS];
    logic [BURST_W-1:0] burst_mem [MAX_PROCS];
    logic [BURST_W-1:0] rem_mem   [MAX_PROCS];
    logic [TICK_W-1:0]  fin_mem   [MAX_PROCS];

    back_state_t          state_reg, state_next;
    logic [JOB_CNT_W-1:0] job_cnt_reg, job_cnt_next;
    logic [JOB_IDX_W-1:0] idx_reg, idx_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic                 found_reg, found_next;
    logic [BURST_W-1:0]   best_reg, best_next;
    logic [JOB_IDX_W-1:0] pick_reg, pick_next;
    logic                 have_reg, have_next;
    logic [ARR_W-1:0]     next_arr_reg, next_arr_next;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [TIME_W-1:0]    out_comp_reg, out_comp_next;
    logic [TIME_W-1:0]    out_turn_reg, out_turn_next;
    logic [TIME_W-1:0]    out_wait_reg, out_wait_next;
    logic                 out_last_reg, out_last_next;

    // table read at the scan / emit index
    logic [ARR_W-1:0]   rd_arr;
    logic [BURST_W-1:0] rd_burst;
    logic [BURST_W-1:0] rd_rem;
    logic [TICK_W-1:0]  rd_fin;

    logic [JOB_CNT_W-1:0]           cnt_m1;
    logic                           at_end;
    logic                           first;
    logic                           live, arrived;
    logic                           found_in, have_in;
    logic [TICK_W-1:0]              end_tick, next_tick, slice;
    logic                           preempt;
    logic                           slot_free;
    logic [TICK_W-1:0]              turn_full, wait_full;
    logic [JOB_IDX_W+OUT_IDX_W-1:0] idx_wide;

    logic                 ld_we;
    logic [JOB_IDX_W-1:0] ld_addr;
    logic                 rem_we, fin_we;
    logic [BURST_W-1:0]   rem_wdata;

    assign rd_arr   = arr_mem[idx_reg];
    assign rd_burst = burst_mem[idx_reg];
    assign rd_rem   = rem_mem[idx_reg];
    assign rd_fin   = fin_mem[idx_reg];

    assign cnt_m1 = job_cnt_reg - 1'b1;
    assign at_end = JOB_CNT_W'(idx_reg) == cnt_m1;
    assign first  = idx_reg == '0;
    assign ld_addr = job_cnt_reg[JOB_IDX_W-1:0];

    // scan: one job per cycle
    assign found_in = found_reg && !first;
    assign have_in  = have_reg && !first;
    assign live     = rd_rem != '0;
    assign arrived  = TICK_W'(rd_arr) <= tick_reg;

    // step
    assign end_tick  = tick_reg + TICK_W'(best_reg);
    assign next_tick = TICK_W'(next_arr_reg);
    assign preempt   = have_reg && (next_tick < end_tick);
    assign slice     = next_tick - tick_reg;

    // emit
    assign slot_free = !out_valid_reg || results.ready;
    assign turn_full = rd_fin - TICK_W'(rd_arr);
    assign wait_full = turn_full - TICK_W'(rd_burst);
    assign idx_wide  = {{OUT_IDX_W{1'b0}}, idx_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (!q_flags.empty && head.last)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (at_end)
                    state_next = ST_STEP;
            ST_STEP:
                if (!found_reg && !have_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_SCAN;
            ST_EMIT:
                if (slot_free && at_end)
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        ld_we         = 1'b0;
        rem_we        = 1'b0;
        fin_we        = 1'b0;
        rem_wdata     = '0;
        job_cnt_next  = job_cnt_reg;
        idx_next      = idx_reg;
        tick_next     = tick_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        pick_next     = pick_reg;
        have_next     = have_reg;
        next_arr_next = next_arr_reg;

        out_valid_next = out_valid_reg && !results.ready;
        out_idx_next   = out_idx_reg;
        out_comp_next  = out_comp_reg;
        out_turn_next  = out_turn_reg;
        out_wait_next  = out_wait_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (!q_flags.empty)
                begin
                    pop = 1'b1;
                    if (head.keep)
                    begin
                        ld_we        = 1'b1;
                        job_cnt_next = job_cnt_reg + 1'b1;
                    end
                    if (head.last)
                    begin
                        idx_next  = '0;
                        tick_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                found_next = found_in || (live && arrived);
                have_next  = have_in || (live && !arrived);
                if (live && arrived && (!found_in || rd_rem < best_reg))
                begin
                    best_next = rd_rem;
                    pick_next = idx_reg;
                end
                if (live && !arrived && (!have_in || rd_arr < next_arr_reg))
                    next_arr_next = rd_arr;
                idx_next = at_end ? '0 : idx_reg + 1'b1;
            end
            ST_STEP:
            begin
                idx_next = '0;
                if (!found_reg)
                begin
                    // nothing ready: skip ahead to the next arrival
                    if (have_reg)
                        tick_next = next_tick;
                end
                else if (preempt)
                begin
                    rem_we    = 1'b1;
                    rem_wdata = best_reg - slice[BURST_W-1:0];
                    tick_next = next_tick;
                end
                else
                begin
                    rem_we    = 1'b1;
                    rem_wdata = '0;
                    fin_we    = 1'b1;
                    tick_next = end_tick;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = idx_wide[OUT_IDX_W-1:0];
                    out_comp_next  = rd_fin[TIME_W-1:0];
                    out_turn_next  = turn_full[TIME_W-1:0];
                    out_wait_next  = wait_full[TIME_W-1:0];
                    out_last_next  = at_end;
                    if (at_end)
                    begin
                        job_cnt_next = '0;
                        idx_next     = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    assign results.valid       = out_valid_reg;
    assign results.job_index   = out_idx_reg;
    assign results.finish_tick = out_comp_reg;
    assign results.turn_ticks  = out_turn_reg;
    assign results.wait_time   = out_wait_reg;
    assign results.last_result = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            arr_mem[ld_addr]   <= head.arrival;
            burst_mem[ld_addr] <= head.burst;
            rem_mem[ld_addr]   <= head.burst;
            // zero-burst job finishes on arrival; others are overwritten later
            fin_mem[ld_addr]   <= TICK_W'(head.arrival);
        end
        if (rem_we)
            rem_mem[pick_reg] <= rem_wdata;
        if (fin_we)
            fin_mem[pick_reg] <= end_tick;
    end

    always_ff @(posedge clk)
    begin
        found_reg    <= found_next;
        best_reg     <= best_next;
        pick_reg     <= pick_next;
        have_reg     <= have_next;
        next_arr_reg <= next_arr_next;
        out_idx_reg  <= out_idx_next;
        out_comp_reg <= out_comp_next;
        out_turn_reg <= out_turn_next;
        out_wait_reg <= out_wait_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            job_cnt_reg   <= '0;
            idx_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_cnt_reg   <= job_cnt_next;
            idx_reg       <= idx_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/srtf_preemptive_scheduler_unit.sv -----
// Preemptive shortest-remaining-time-first scheduler. Each transfer on jobs loads one job
// (arrival tick, burst length); up to MAX_PROCS jobs are held and any beyond that are
// dropped. The transfer flagged last_job starts the run on the held jobs: time starts at
// tick 0, the arrived unfinished job with the least remaining time runs (ties to the
// lowest load index), idle time jumps to the next arrival, and a zero-burst job finishes
// at its arrival. Then one result per job leaves on results in load order, the final one
// with last_result set, and the block is ready for a new set. Jobs are loaded through a
// two-entry queue, which holds up to two jobs while the engine is busy; once it is full,
// jobs.ready drops. The run advances event by event (a completion or an arrival); each
// event scans the job table one entry per cycle and then updates the time and the picked
// job in a step state, after which the results are issued, each held until taken; new
// jobs queue up while this goes on and are loaded once the last result has been issued.
module srtf_preemptive_scheduler_unit (
    input  logic       clk,
    input  logic       rst_n,
    srtf_in_if.sink    jobs,
    srtf_out_if.source results
);
    import srtf_pkg::*;

    logic      push;
    job_item_t push_item;
    logic      pop;
    job_item_t head;
    q_flags_t  q_flags;

    // intake: accepts jobs, marks overflow, feeds the queue
    srtf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .jobs      (jobs),
        .q_flags   (q_flags),
        .push      (push),
        .push_item (push_item)
    );

    // decouples intake from the scheduling engine
    srtf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_flags   (q_flags)
    );

    // job table, scheduling run and result output register
    srtf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_flags (q_flags),
        .pop     (pop),
        .results (results)
    );

endmodule

// ----- src/srtf_chk.sv -----
`include "srtf_preemptive_scheduler_unit_assert.svh"

module srtf_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           valid,
    input logic                           ready,
    input logic [srtf_pkg::OUT_IDX_W-1:0] job_index,
    input logic [srtf_pkg::TIME_W-1:0]    finish_tick,
    input logic [srtf_pkg::TIME_W-1:0]    turn_ticks,
    input logic [srtf_pkg::TIME_W-1:0]    wait_time,
    input logic                           last_result
);
    import srtf_pkg::*;

    logic [OUT_IDX_W+3*TIME_W:0] out_bits;

    assign out_bits = {job_index, finish_tick, turn_ticks, wait_time, last_result};

    // stalled result holds
    `SRTF_ASSERT_NXT(a_out_hold, valid && !ready, valid && $stable(out_bits))

    // a job never finishes before it arrives
    `SRTF_ASSERT_IMP(a_turn_le_comp, valid, turn_ticks <= finish_tick)

    // a job is served for its full burst before it finishes
    `SRTF_ASSERT_IMP(a_wait_le_turn, valid, wait_time <= turn_ticks)

endmodule

bind srtf_preemptive_scheduler_unit srtf_chk u_srtf_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (results.valid),
    .ready       (results.ready),
    .job_index   (results.job_index),
    .finish_tick (results.finish_tick),
    .turn_ticks  (results.turn_ticks),
    .wait_time   (results.wait_time),
    .last_result (results.last_result)
);
